// ===== rtl/core/const_fold_integer_alu_macros.svh =====
// Assertion macros for the constant-folding ALU.
// Used by const_fold_integer_alu.sv; assumes clk_i and rst_ni are in scope.
`ifndef CONST_FOLD_INTEGER_ALU_MACROS_SVH
`define CONST_FOLD_INTEGER_ALU_MACROS_SVH

// Checked only outside reset.
`define CFA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define CFA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/core/cfa_pkg.sv =====
// Shared types, codes and helpers for the constant-folding ALU.
// No dependencies; imported by every module of the block.
`default_nettype none

package cfa_pkg;

  localparam int unsigned XLEN = 64;
  localparam int unsigned DefDataWidth = 64;
  localparam logic [XLEN-1:0] SignedMin = {1'b1, {(XLEN-1){1'b0}}};

  typedef enum logic [4:0] {
    OP_ADD  = 5'd0,  OP_SUB  = 5'd1,  OP_MUL  = 5'd2,  OP_DIV  = 5'd3,
    OP_REM  = 5'd4,  OP_AND  = 5'd5,  OP_OR   = 5'd6,  OP_XOR  = 5'd7,
    OP_SHL  = 5'd8,  OP_SHR  = 5'd9,  OP_EQ   = 5'd10, OP_NE   = 5'd11,
    OP_LT   = 5'd12, OP_LE   = 5'd13, OP_GT   = 5'd14, OP_GE   = 5'd15,
    OP_LAND = 5'd16, OP_LOR  = 5'd17, OP_NEG  = 5'd18, OP_PLUS = 5'd19,
    OP_NOT  = 5'd20, OP_LNOT = 5'd21
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DIV_ZERO = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_BAD_OP   = 2'd3
  } status_e;

  localparam logic [1:0] SizeEightBytes = 2'd3;

  // Everything an item needs besides the divider datapath.
  typedef struct packed {
    logic [XLEN-1:0] value;
    status_e         status;
    logic            is_bool;
    logic            cut;
    logic            sgn;
    logic [1:0]      size_code;
    logic            is_div;
    logic            is_rem;
    logic            q_neg;
    logic            r_neg;
  } cfa_side_t;

  // One slot of the divider chain.
  typedef struct packed {
    logic            valid;
    logic [XLEN-1:0] rem;
    logic [XLEN-1:0] dvd;
    logic [XLEN-1:0] dsr;
    cfa_side_t       side;
  } cfa_cell_t;

  function automatic logic less_than(logic [XLEN-1:0] a, logic [XLEN-1:0] b,
                                     logic sgn);
    logic [XLEN-1:0] ax;
    logic [XLEN-1:0] bx;
    ax = sgn ? (a ^ SignedMin) : a;
    bx = sgn ? (b ^ SignedMin) : b;
    return ax < bx;
  endfunction

  // Cut to bits, then sign- or zero-extend back to XLEN.
  function automatic logic [XLEN-1:0] fit_width(logic [XLEN-1:0] v, logic [6:0] bits,
                                                logic sgn);
    logic [XLEN-1:0] mask;
    logic [XLEN-1:0] top;
    logic [XLEN-1:0] r;
    mask = ({{(XLEN-1){1'b0}}, 1'b1} << bits) - {{(XLEN-1){1'b0}}, 1'b1};
    top  = v >> (bits - 7'd1);
    r    = v & mask;
    if (sgn && top[0]) begin
      r = r | ~mask;
    end
    if (bits >= 7'(XLEN)) begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/cfa_prep.sv =====
// Front end: operand decode, split multiply and all results that need no divider.
// Depends on cfa_pkg; feeds the first divider cell.
`default_nettype none

module cfa_prep
  import cfa_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [4:0]      opcode_i,
  input  logic [XLEN-1:0] left_operand_i,
  input  logic [XLEN-1:0] right_operand_i,
  input  logic [1:0]      size_code_i,
  input  logic            operand_signed_i,
  output cfa_cell_t       cell_o
);

  localparam int unsigned Half = XLEN / 2;

  // Stage A: register operands, the low partial product and the sum of the cross products.
  logic            valid_q;
  logic [4:0]      op_q;
  logic [XLEN-1:0] a_q, b_q;
  logic [1:0]      size_q;
  logic            sgn_q;
  logic [XLEN-1:0] p_ll_q;
  logic [Half-1:0] p_cross_q;

  logic [XLEN-1:0] p_lh, p_hl;

  always_comb begin
    p_lh = left_operand_i[Half-1:0] * right_operand_i[XLEN-1:Half];
    p_hl = left_operand_i[XLEN-1:Half] * right_operand_i[Half-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op_q      <= opcode_i;
      a_q       <= left_operand_i;
      b_q       <= right_operand_i;
      size_q    <= size_code_i;
      sgn_q     <= operand_signed_i;
      p_ll_q    <= XLEN'(left_operand_i[Half-1:0]) * XLEN'(right_operand_i[Half-1:0]);
      p_cross_q <= p_lh[Half-1:0] + p_hl[Half-1:0];
    end
  end

  // Stage B: pick the result.
  cfa_side_t       side;
  logic [5:0]      sh;
  logic [XLEN-1:0] mag_a, mag_b;
  logic [XLEN-1:0] ones;

  always_comb begin
    ones  = '1;
    sh    = (size_q == SizeEightBytes) ? b_q[5:0] : {1'b0, b_q[4:0]};
    mag_a = (sgn_q && a_q[XLEN-1]) ? (~a_q + 1'b1) : a_q;
    mag_b = (sgn_q && b_q[XLEN-1]) ? (~b_q + 1'b1) : b_q;

    side           = '0;
    side.status    = ST_OK;
    side.cut       = 1'b1;
    side.sgn       = sgn_q;
    side.size_code = size_q;
    side.q_neg     = sgn_q & (a_q[XLEN-1] ^ b_q[XLEN-1]);
    side.r_neg     = sgn_q & a_q[XLEN-1];

    unique case (op_q)
      OP_ADD: side.value = a_q + b_q;
      OP_SUB: side.value = a_q - b_q;
      OP_MUL: side.value = p_ll_q + {p_cross_q, {Half{1'b0}}};
      OP_DIV, OP_REM: begin
        side.is_div = 1'b1;
        side.is_rem = (op_q == OP_REM);
        if (b_q == '0) begin
          side.status = ST_DIV_ZERO;
        end else if (sgn_q && a_q == SignedMin && b_q == ones) begin
          side.status = ST_OVERFLOW;
        end
      end
      OP_AND: side.value = a_q & b_q;
      OP_OR:  side.value = a_q | b_q;
      OP_XOR: side.value = a_q ^ b_q;
      OP_SHL: side.value = a_q << sh;
      OP_SHR: side.value = sgn_q ? XLEN'($signed(a_q) >>> sh) : (a_q >> sh);
      OP_EQ:  begin side.value = XLEN'(a_q == b_q);               side.is_bool = 1'b1; end
      OP_NE:  begin side.value = XLEN'(a_q != b_q);               side.is_bool = 1'b1; end
      OP_LT:  begin side.value = XLEN'(less_than(a_q, b_q, sgn_q));  side.is_bool = 1'b1; end
      OP_LE:  begin side.value = XLEN'(!less_than(b_q, a_q, sgn_q)); side.is_bool = 1'b1; end
      OP_GT:  begin side.value = XLEN'(less_than(b_q, a_q, sgn_q));  side.is_bool = 1'b1; end
      OP_GE:  begin side.value = XLEN'(!less_than(a_q, b_q, sgn_q)); side.is_bool = 1'b1; end
      OP_LAND: begin
        side.value = XLEN'(a_q != '0 && b_q != '0); side.is_bool = 1'b1;
      end
      OP_LOR: begin
        side.value = XLEN'(a_q != '0 || b_q != '0); side.is_bool = 1'b1;
      end
      OP_NEG:  side.value = '0 - a_q;
      OP_PLUS: begin side.value = a_q; side.cut = 1'b0; end
      OP_NOT:  side.value = ~a_q;
      OP_LNOT: begin side.value = XLEN'(a_q == '0); side.is_bool = 1'b1; end
      default: side.status = ST_BAD_OP;
    endcase
  end

  // Reset clears only the valid bit; the payload just holds.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_o.valid <= 1'b0;
    end else if (en_i) begin
      cell_o.valid <= valid_q;
      cell_o.rem   <= '0;
      cell_o.dvd   <= mag_a;
      cell_o.dsr   <= mag_b;
      cell_o.side  <= side;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/cfa_div_cell.sv =====
// One restoring-division step: one quotient bit per cell.
// Depends on cfa_pkg; chained in the top level.
`default_nettype none

module cfa_div_cell
  import cfa_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  cfa_cell_t cell_i,
  output cfa_cell_t cell_o
);

  logic [XLEN:0] shifted;
  logic [XLEN:0] diff;

  always_comb begin
    shifted = {cell_i.rem, cell_i.dvd[XLEN-1]};
    diff    = shifted - {1'b0, cell_i.dsr};
  end

  // Keep the difference when it does not go negative; shift the bit into dvd.
  // Reset clears only the valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_o.valid <= 1'b0;
    end else if (en_i) begin
      cell_o.valid <= cell_i.valid;
      cell_o.rem   <= diff[XLEN] ? shifted[XLEN-1:0] : diff[XLEN-1:0];
      cell_o.dvd   <= {cell_i.dvd[XLEN-2:0], ~diff[XLEN]};
      cell_o.dsr   <= cell_i.dsr;
      cell_o.side  <= cell_i.side;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/cfa_finish.sv =====
// Back end: sign fix of quotient and remainder, width cut, output register.
// Depends on cfa_pkg; takes the last divider cell.
`default_nettype none

module cfa_finish
  import cfa_pkg::*;
#(
  parameter int unsigned DataWidth = DefDataWidth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  cfa_cell_t       cell_i,
  output logic            out_valid_o,
  output logic [XLEN-1:0] result_value_o,
  output logic            result_is_bool_o,
  output logic [1:0]      status_o
);

  logic [6:0]      bits;
  logic [6:0]      full;
  logic [XLEN-1:0] q, r, v;
  logic            isb;

  always_comb begin
    full = 7'd8 << cell_i.side.size_code;
    bits = (full > 7'(DataWidth)) ? 7'(DataWidth) : full;
    q    = cell_i.side.q_neg ? ('0 - cell_i.dvd) : cell_i.dvd;
    r    = cell_i.side.r_neg ? ('0 - cell_i.rem) : cell_i.rem;
    v    = cell_i.side.is_div ? (cell_i.side.is_rem ? r : q) : cell_i.side.value;
    isb  = cell_i.side.is_bool;
    if (cell_i.side.status != ST_OK) begin
      v   = '0;
      isb = 1'b0;
    end else if (!isb && cell_i.side.cut) begin
      v = fit_width(v, bits, cell_i.side.sgn);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (en_i) begin
      out_valid_o <= cell_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      result_value_o   <= v;
      result_is_bool_o <= isb;
      status_o         <= cell_i.side.status;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/const_fold_integer_alu.sv =====
// Top level of the constant-folding integer ALU: front end, divider chain, back end.
// Depends on cfa_pkg, cfa_prep, cfa_div_cell, cfa_finish and the macro header.
//
//   channel | handshake               | payload
//   input   | in_valid_i / in_stall_o | opcode, operands, size_code, operand_signed
//   output  | out_valid_o/out_stall_i | result_value, result_is_bool, status
//
// Every item reaches the output register along the same path from its accepting edge:
// that edge loads the first of two front-end stages, then one cell per quotient bit
// (64 cells) and one output stage follow. All opcodes travel the same chain, so
// results leave in order; one item per cycle enters while the chain is not stalled.
// Reset clears only the valid bits of each stage.
// A held output stalls the whole chain; in_stall_o rises only while a finished
// item waits in the output register and out_stall_i is high.
`default_nettype none

module const_fold_integer_alu
  import cfa_pkg::*;
#(
  parameter int unsigned DataWidth = DefDataWidth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [4:0]      opcode_i,
  input  logic [XLEN-1:0] left_operand_i,
  input  logic [XLEN-1:0] right_operand_i,
  input  logic [1:0]      size_code_i,
  input  logic            operand_signed_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [XLEN-1:0] result_value_o,
  output logic            result_is_bool_o,
  output logic [1:0]      status_o
);

`include "const_fold_integer_alu_macros.svh"

  // Advance the whole chain unless the output item is held.
  logic advance;
  assign advance    = !(out_valid_o && out_stall_i);
  assign in_stall_o = !advance;

  cfa_cell_t chain [0:XLEN];

  cfa_prep u_prep (
    .clk_i,
    .rst_ni,
    .en_i             (advance),
    .valid_i          (in_valid_i),
    .opcode_i,
    .left_operand_i,
    .right_operand_i,
    .size_code_i,
    .operand_signed_i,
    .cell_o           (chain[0])
  );

  for (genvar i = 0; i < XLEN; i++) begin : g_cell
    cfa_div_cell u_cell (
      .clk_i,
      .rst_ni,
      .en_i   (advance),
      .cell_i (chain[i]),
      .cell_o (chain[i+1])
    );
  end

  cfa_finish #(
    .DataWidth (DataWidth)
  ) u_finish (
    .clk_i,
    .rst_ni,
    .en_i             (advance),
    .cell_i           (chain[XLEN]),
    .out_valid_o,
    .result_value_o,
    .result_is_bool_o,
    .status_o
  );

  `CFA_ASSERT(a_err_zero, out_valid_o && status_o != ST_OK |-> result_value_o == '0 && !result_is_bool_o, "error item carries a value")
  `CFA_ASSERT(a_bool_range, out_valid_o && result_is_bool_o |-> result_value_o[XLEN-1:1] == '0, "boolean result not 0 or 1")
  `CFA_ASSERT_ALWAYS(a_stall_cause, in_stall_o |-> out_valid_o, "stall without a held item")
  `CFA_ASSERT(a_chain_hold, !advance |=> $stable(chain[XLEN].valid) && $stable(result_value_o), "chain moved while held")

endmodule

`default_nettype wire
